// ----- src/ctfr_pkg.sv -----
// shared types and constants for the checksummed text frame receiver
// no dependencies; used by every module in src
package ctfr_pkg;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam logic       REQ_BYTE = 1'b0;
  localparam logic       REQ_TICK = 1'b1;

  localparam logic       KIND_BYTE   = 1'b0;
  localparam logic       KIND_STATUS = 1'b1;

  localparam logic [2:0] CLS_RAW     = 3'd0;
  localparam logic [2:0] CLS_LABEL   = 3'd1;
  localparam logic [2:0] CLS_TAB     = 3'd2;
  localparam logic [2:0] CLS_VALUE   = 3'd3;
  localparam logic [2:0] CLS_CR      = 3'd4;
  localparam logic [2:0] CLS_FRAMING = 3'd5;

  localparam logic [1:0] REG_RAW_MODE     = 2'd0;
  localparam logic [1:0] REG_MAX_LENGTH   = 2'd1;
  localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd2;

  localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] COUNT_MAX          = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_SKIP,
    PH_LABEL,
    PH_VALUE
  } phase_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  out_byte;
    logic [2:0]  byte_class;
    logic        frame_ok;
    logic [15:0] frame_length;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;
  } out_item_t;

  // one accepted item as seen by the back end: a byte beat, a status beat or both
  typedef struct packed {
    logic        has_byte;
    logic        has_status;
    logic [7:0]  rx_byte;
    logic [2:0]  byte_class;
    logic [15:0] byte_len;
    logic        status_ok;
    logic [15:0] status_len;
    logic [31:0] good_count;
    logic [31:0] bad_count;
  } cmd_t;

endpackage

// ----- src/checksummed_text_frame_receiver_core.sv -----
// top level of the checksummed text frame receiver
// depends on ctfr_pkg, ctfr_front, ctfr_queue, ctfr_back
//
//   channel | direction | handshake        | beat
//   in      | input     | in_valid/in_stall | in_item_t: request type and byte
//   out     | output    | out_valid/out_stall | out_item_t: classified byte or status
//   cfg     | input     | cfg_wen          | register index and 16-bit data
//
// while in_stall is low, one item per cycle enters the front end, which updates
// the frame state in that cycle; an item that ends a frame on its own byte gives
// two beats, a byte beat and then a status beat that waits in the back end's
// pending register; results pass through the queue and the output register
// rst is synchronous; in_stall rises only when the queue is full
module checksummed_text_frame_receiver_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ctfr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ctfr_pkg::out_item_t out_data,
  input  logic                cfg_wen,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  logic           q_full, q_nonempty, q_pop, push, accept;
  ctfr_pkg::cmd_t cmd, q_head;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  ctfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .item      (in_data),
    .push      (push),
    .cmd       (cmd)
  );

  ctfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  ctfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- src/ctfr_front.sv -----
// front end: config registers, frame state machine, byte classification
// depends on ctfr_pkg; feeds ctfr_queue with one command per item that takes a byte or ends a frame
module ctfr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wen,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_wdata,
  input  logic            accept,
  input  ctfr_pkg::in_item_t item,
  output logic            push,
  output ctfr_pkg::cmd_t  cmd
);

  logic        raw_mode;
  logic [15:0] max_frame_length;
  logic [15:0] idle_timeout_ticks;

  ctfr_pkg::phase_t phase, phase_next;
  logic [15:0] byte_count;
  logic [7:0]  running_sum;
  logic [15:0] idle_count;
  logic [31:0] good_count;
  logic [31:0] bad_count;

  logic        is_byte, is_cr, is_tab;
  logic [15:0] count_inc, idle_inc;
  logic [7:0]  sum_new;
  logic        byte_take, tick_end, len_end, frame_end, frame_ok;
  logic [2:0]  cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode           <= 1'b0;
      max_frame_length   <= 16'd0;
      idle_timeout_ticks <= ctfr_pkg::IDLE_TIMEOUT_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        ctfr_pkg::REG_RAW_MODE:     raw_mode           <= cfg_wdata[0];
        ctfr_pkg::REG_MAX_LENGTH:   max_frame_length   <= cfg_wdata;
        ctfr_pkg::REG_IDLE_TIMEOUT: idle_timeout_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign is_byte   = (item.req_type == ctfr_pkg::REQ_BYTE);
  assign is_cr     = (item.rx_byte == ctfr_pkg::CH_CR);
  assign is_tab    = (item.rx_byte == ctfr_pkg::CH_TAB);
  assign count_inc = (byte_count == ctfr_pkg::COUNT_MAX) ? byte_count : byte_count + 16'd1;
  assign idle_inc  = (idle_count == ctfr_pkg::COUNT_MAX) ? idle_count : idle_count + 16'd1;
  assign sum_new   = running_sum + item.rx_byte;

  // a zero timeout behaves like one since idle_inc is at least one
  assign byte_take = is_byte && (phase != ctfr_pkg::PH_WAIT || is_cr);
  assign tick_end  = !is_byte && (phase != ctfr_pkg::PH_WAIT) && (idle_inc >= idle_timeout_ticks);
  assign len_end   = byte_take && (max_frame_length != 16'd0) && (count_inc >= max_frame_length);
  assign frame_end = tick_end || len_end;
  assign frame_ok  = raw_mode || ((is_byte ? sum_new : running_sum) == 8'd0);

  // next state
  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (frame_end) begin
        phase_next = ctfr_pkg::PH_WAIT;
      end else if (is_byte) begin
        unique case (phase)
          ctfr_pkg::PH_WAIT:  if (is_cr) phase_next = ctfr_pkg::PH_SKIP;
          ctfr_pkg::PH_SKIP:  phase_next = ctfr_pkg::PH_LABEL;
          ctfr_pkg::PH_LABEL: begin
            if (is_cr) phase_next = ctfr_pkg::PH_SKIP;
            else if (is_tab) phase_next = ctfr_pkg::PH_VALUE;
          end
          ctfr_pkg::PH_VALUE: if (is_cr) phase_next = ctfr_pkg::PH_SKIP;
          default: phase_next = ctfr_pkg::PH_WAIT;
        endcase
      end
    end
  end

  // byte class from the current phase and byte; raw mode forces the raw class
  always_comb begin
    unique case (phase)
      ctfr_pkg::PH_WAIT, ctfr_pkg::PH_SKIP: cls = ctfr_pkg::CLS_FRAMING;
      ctfr_pkg::PH_LABEL: begin
        if (is_cr) cls = ctfr_pkg::CLS_CR;
        else if (is_tab) cls = ctfr_pkg::CLS_TAB;
        else cls = ctfr_pkg::CLS_LABEL;
      end
      ctfr_pkg::PH_VALUE: cls = is_cr ? ctfr_pkg::CLS_CR : ctfr_pkg::CLS_VALUE;
      default: cls = ctfr_pkg::CLS_FRAMING;
    endcase
    if (raw_mode) cls = ctfr_pkg::CLS_RAW;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ctfr_pkg::PH_WAIT;
      byte_count  <= 16'd0;
      running_sum <= 8'd0;
      idle_count  <= 16'd0;
      good_count  <= 32'd0;
      bad_count   <= 32'd0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        if (is_byte) begin
          idle_count <= 16'd0;
        end else if (phase != ctfr_pkg::PH_WAIT) begin
          idle_count <= idle_inc;
        end
        if (byte_take) begin
          byte_count  <= count_inc;
          running_sum <= sum_new;
        end
        if (frame_end) begin
          byte_count  <= 16'd0;
          running_sum <= 8'd0;
          idle_count  <= 16'd0;
          if (frame_ok) good_count <= good_count + 32'd1;
          else bad_count <= bad_count + 32'd1;
        end
      end
    end
  end

  assign push = accept && (byte_take || frame_end);

  always_comb begin
    cmd.has_byte   = byte_take;
    cmd.has_status = frame_end;
    cmd.rx_byte    = item.rx_byte;
    cmd.byte_class = cls;
    cmd.byte_len   = count_inc;
    cmd.status_ok  = frame_ok;
    cmd.status_len = is_byte ? count_inc : byte_count;
    cmd.good_count = good_count;
    cmd.bad_count  = bad_count;
  end

endmodule

// ----- src/ctfr_queue.sv -----
// two-entry command queue between front and back end
// depends on ctfr_pkg for the command type
module ctfr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ctfr_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output ctfr_pkg::cmd_t head
);

  ctfr_pkg::cmd_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/ctfr_back.sv -----
// back end: turns commands into output beats behind an output register
// depends on ctfr_pkg; pops ctfr_queue
module ctfr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_nonempty,
  input  ctfr_pkg::cmd_t    q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output ctfr_pkg::out_item_t out_data
);

  logic                pend;
  ctfr_pkg::out_item_t pend_data;
  ctfr_pkg::out_item_t byte_beat, status_beat;
  logic                can_load;

  always_comb begin
    byte_beat.result_kind  = ctfr_pkg::KIND_BYTE;
    byte_beat.out_byte     = q_head.rx_byte;
    byte_beat.byte_class   = q_head.byte_class;
    byte_beat.frame_ok     = 1'b0;
    byte_beat.frame_length = q_head.byte_len;
    byte_beat.good_frames  = q_head.good_count;
    byte_beat.bad_frames   = q_head.bad_count;

    // counters after this frame's update
    status_beat.result_kind  = ctfr_pkg::KIND_STATUS;
    status_beat.out_byte     = 8'd0;
    status_beat.byte_class   = ctfr_pkg::CLS_RAW;
    status_beat.frame_ok     = q_head.status_ok;
    status_beat.frame_length = q_head.status_len;
    status_beat.good_frames  = q_head.good_count + {31'd0, q_head.status_ok};
    status_beat.bad_frames   = q_head.bad_count + {31'd0, !q_head.status_ok};
  end

  assign can_load = !out_valid || !out_stall;
  assign q_pop    = can_load && !pend && q_nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (can_load) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else if (q_nonempty) begin
        out_valid <= 1'b1;
        pend      <= q_head.has_byte && q_head.has_status;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      if (pend) begin
        out_data <= pend_data;
      end else if (q_nonempty) begin
        out_data  <= q_head.has_byte ? byte_beat : status_beat;
        pend_data <= status_beat;
      end
    end
  end

endmodule
